// ===== sv/dopcs_pkg.sv =====
package dopcs_pkg;

  // default geometry
  localparam int NumBanksDef = 4;
  localparam int RowBitsDef  = 16;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_PRECHARGE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVATE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_READ_LAT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_LAT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CCD_SHORT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CCD_LONG   = 3'd5;

  // register reset values
  localparam logic [CfgDataW-1:0] RST_PRECHARGE = 8'd24;
  localparam logic [CfgDataW-1:0] RST_ACTIVATE  = 8'd24;
  localparam logic [CfgDataW-1:0] RST_READ_LAT  = 8'd24;
  localparam logic [CfgDataW-1:0] RST_WRITE_LAT = 8'd20;
  localparam logic [CfgDataW-1:0] RST_CCD_SHORT = 8'd4;
  localparam logic [CfgDataW-1:0] RST_CCD_LONG  = 8'd8;

  // fixed burst overhead added to the column latencies
  localparam logic [CfgDataW:0] BurstExtra = 9'd4;

  // request kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  // dram command codes
  localparam logic [1:0] CMD_PRE = 2'd0;
  localparam logic [1:0] CMD_ACT = 2'd1;
  localparam logic [1:0] CMD_RD  = 2'd2;
  localparam logic [1:0] CMD_WR  = 2'd3;

  typedef struct packed {
    logic [31:0] start_time;
    logic [1:0]  command;
    logic [1:0]  bank_index;
    logic [1:0]  group_index;
    logic [15:0] row_address;
    logic [6:0]  column_high;
    logic        same_group;
    logic [15:0] gap_since_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] issue_time;
    logic [1:0]  dram_command;
    logic [1:0]  out_group;
    logic [1:0]  out_bank;
    logic [15:0] address_value;
    logic [31:0] finish_time;
    logic        last;
  } out_item_t;

  // commands still to be issued for the request held in the job register
  typedef struct packed {
    logic pre;
    logic act;
    logic col;
  } pend_t;

endpackage

// ===== sv/dram_open_page_command_sequencer_unit.sv =====
// channel | direction | beat type            | handshake
// in      | input     | dopcs_pkg::in_item_t  | in_valid_i / in_stall_o
// out     | output    | dopcs_pkg::out_item_t | out_valid_o / out_stall_i
// cfg     | input     | 8-bit register write  | cfg_we_i, cfg_idx_i, no wait
//
// a request gives up to three commands, one result beat per cycle while the
// output does not stall, so a request holds the job register until its last command issues
// bank state is updated on accept, so the next request can be taken in the
// cycle the last command of the current one moves to the output register
// a request that needs no command is absorbed on accept with no beat
// reset leaves all banks precharged and the timing registers at defaults
// a stall on the output holds the result register and the job register
module dram_open_page_command_sequencer_unit #(
  parameter int NUM_BANKS = dopcs_pkg::NumBanksDef,
  parameter int ROW_BITS  = dopcs_pkg::RowBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  dopcs_pkg::in_item_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output dopcs_pkg::out_item_t               out_data_o,
  input  logic                               cfg_we_i,
  input  logic [dopcs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dopcs_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int BankW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  // timing registers
  logic [dopcs_pkg::CfgDataW-1:0] trp_q, trcd_q, tcas_q, tcwd_q, ccds_q, ccdl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trp_q  <= dopcs_pkg::RST_PRECHARGE;
      trcd_q <= dopcs_pkg::RST_ACTIVATE;
      tcas_q <= dopcs_pkg::RST_READ_LAT;
      tcwd_q <= dopcs_pkg::RST_WRITE_LAT;
      ccds_q <= dopcs_pkg::RST_CCD_SHORT;
      ccdl_q <= dopcs_pkg::RST_CCD_LONG;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dopcs_pkg::CFG_PRECHARGE: trp_q  <= cfg_data_i;
        dopcs_pkg::CFG_ACTIVATE:  trcd_q <= cfg_data_i;
        dopcs_pkg::CFG_READ_LAT:  tcas_q <= cfg_data_i;
        dopcs_pkg::CFG_WRITE_LAT: tcwd_q <= cfg_data_i;
        dopcs_pkg::CFG_CCD_SHORT: ccds_q <= cfg_data_i;
        dopcs_pkg::CFG_CCD_LONG:  ccdl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bank state
  logic [ROW_BITS-1:0]  open_row_q [NUM_BANKS];
  logic [NUM_BANKS-1:0] row_is_open_q;
  logic [1:0]           prev_bank_q;
  logic                 prev_valid_q;

  // job register: one request being expanded into commands
  logic                 job_valid_q;
  dopcs_pkg::pend_t     pend_q;
  logic [31:0]          time_q;
  logic                 job_wr_q;
  logic [1:0]           job_grp_q, job_bank_q;
  logic [15:0]          job_row_q;
  logic [6:0]           job_col_q;
  logic [8:0]           gap_add_q;

  // result register
  logic                 out_valid_q;
  dopcs_pkg::out_item_t out_q;

  logic in_accept, emit, job_done;

  // decode of the incoming request against the bank state
  logic [31:0]          bank_mod32;
  logic [1:0]           bank_mod;
  logic [BankW-1:0]     bank_sel;
  logic [ROW_BITS-1:0]  row_sel;
  logic                 need_pre, need_act, is_rd, is_wr;
  logic [14:0]          half_gap;
  logic [7:0]           ccd_sel;
  logic [8:0]           gap_add;
  dopcs_pkg::pend_t     pend_new;

  always_comb begin
    // fold the bank index into the bank count by repeated subtraction
    bank_mod32 = 32'(in_data_i.bank_index);
    for (int k = 0; k < 3; k++) begin
      if (bank_mod32 >= 32'(NUM_BANKS)) begin
        bank_mod32 = bank_mod32 - 32'(NUM_BANKS);
      end
    end
    bank_mod   = bank_mod32[1:0];
    bank_sel   = BankW'(bank_mod);
    row_sel    = ROW_BITS'(in_data_i.row_address);
    need_pre   = row_is_open_q[bank_sel] && (open_row_q[bank_sel] != row_sel);
    need_act   = need_pre || !row_is_open_q[bank_sel];
    is_rd      = (in_data_i.command == dopcs_pkg::KIND_READ) ||
                 (in_data_i.command == dopcs_pkg::KIND_FETCH);
    is_wr      = (in_data_i.command == dopcs_pkg::KIND_WRITE);
    half_gap   = in_data_i.gap_since_last[15:1];
    ccd_sel    = in_data_i.same_group ? ccdl_q : ccds_q;
    gap_add    = '0;
    if (is_rd && prev_valid_q && (bank_mod == prev_bank_q) &&
        (half_gap < 15'(ccd_sel))) begin
      gap_add = {ccd_sel - half_gap[7:0], 1'b0};
    end
    pend_new.pre = need_pre;
    pend_new.act = need_act;
    pend_new.col = is_rd || is_wr;
  end

  // command selection and timing for the head of the job
  logic [1:0]  cur_cmd;
  logic [9:0]  cur_delay;
  logic [8:0]  cur_off;
  logic [10:0] off_delay;
  logic [31:0] issue_time, next_time;
  logic [15:0] cur_addr;
  dopcs_pkg::pend_t pend_next;

  always_comb begin
    pend_next = pend_q;
    cur_off   = '0;
    if (pend_q.pre) begin
      cur_cmd       = dopcs_pkg::CMD_PRE;
      cur_delay     = {1'b0, trp_q, 1'b0};
      cur_addr      = '0;
      pend_next.pre = 1'b0;
    end else if (pend_q.act) begin
      cur_cmd       = dopcs_pkg::CMD_ACT;
      cur_delay     = {1'b0, trcd_q, 1'b0};
      cur_addr      = job_row_q;
      pend_next.act = 1'b0;
    end else begin
      cur_cmd       = job_wr_q ? dopcs_pkg::CMD_WR : dopcs_pkg::CMD_RD;
      cur_delay     = job_wr_q ? {({1'b0, tcwd_q} + dopcs_pkg::BurstExtra), 1'b0}
                               : {({1'b0, tcas_q} + dopcs_pkg::BurstExtra), 1'b0};
      cur_off       = job_wr_q ? 9'd0 : gap_add_q;
      cur_addr      = {9'd0, job_col_q};
      pend_next.col = 1'b0;
    end
    off_delay  = 11'(cur_off) + 11'(cur_delay);
    // gap and delays are even, so rounding up the start is enough
    issue_time = time_q + 32'(time_q[0]) + 32'(cur_off);
    next_time  = time_q + 32'(time_q[0]) + 32'(off_delay);
  end

  // handshake
  assign emit       = job_valid_q && (!out_valid_q || !out_stall_i);
  assign job_done   = emit && (pend_next == '0);
  assign in_stall_o = job_valid_q && !job_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  // bank state update on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_is_open_q <= '0;
      prev_bank_q   <= '0;
      prev_valid_q  <= 1'b0;
    end else if (in_accept) begin
      row_is_open_q[bank_sel] <= 1'b1;
      prev_bank_q             <= bank_mod;
      prev_valid_q            <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      open_row_q[bank_sel] <= row_sel;
    end
  end

  // job register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      pend_q      <= '0;
    end else if (in_accept) begin
      job_valid_q <= (pend_new != '0);
      pend_q      <= pend_new;
    end else if (emit) begin
      job_valid_q <= !job_done;
      pend_q      <= pend_next;
    end
  end

  // job register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      time_q     <= in_data_i.start_time;
      job_wr_q   <= is_wr;
      job_grp_q  <= in_data_i.group_index;
      job_bank_q <= bank_mod;
      job_row_q  <= 16'(row_sel);
      job_col_q  <= in_data_i.column_high;
      gap_add_q  <= gap_add;
    end else if (emit) begin
      time_q <= next_time;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.issue_time    <= issue_time;
      out_q.dram_command  <= cur_cmd;
      out_q.out_group     <= job_grp_q;
      out_q.out_bank      <= job_bank_q;
      out_q.address_value <= cur_addr;
      out_q.finish_time   <= job_done ? next_time : 32'd0;
      out_q.last          <= job_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a live job always has a command left to issue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (pend_q != '0))
    else $error("job register holds no pending command");

  // every command issues on an even cpu clock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.issue_time[0])
    else $error("command issued on an odd clock");

  // only the final beat of a request carries a finish time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> (out_data_o.finish_time == 32'd0))
    else $error("finish time on a non-final beat");

  // after any request its bank is left open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> row_is_open_q[$past(bank_sel)])
    else $error("addressed bank not open after request");

  // no new request while the current job is blocked from issuing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !emit) |-> in_stall_o)
    else $error("request taken while job blocked");

endmodule
